// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

// File: rtl/core/mss_pkg.sv
// Package with types and constants of the maximum-sum subrectangle block.
`default_nettype none
package mss_pkg;
  localparam int MaxRows = 64;
  localparam int MaxCols = 64;
  localparam int DataWidth = 16;
  localparam int IdxW = $clog2(MaxRows > MaxCols ? MaxRows : MaxCols);
  localparam int RowW = $clog2(MaxRows);
  localparam int ColW = $clog2(MaxCols);
  localparam int AddrW = $clog2(MaxRows * MaxCols);
  localparam int DimW = 7;
  localparam int AccW = DataWidth + ColW;
  localparam int SumW = AccW + RowW + 1;
  localparam int OutSumW = 28;
  localparam logic [0:0] CfgRowCount = 1'b0;
  localparam logic [0:0] CfgColCount = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD, ST_COL_INIT, ST_ACCUM, ST_ACCUM_WAIT, ST_SCAN, ST_SCAN_WAIT, ST_PAIR_END, ST_DONE
  } state_t;

  typedef struct packed {
    logic load_we;
    logic clr_load;
    logic clr_best;
    logic clr_l;
    logic set_r_to_l;
    logic inc_l;
    logic inc_r;
    logic clr_row;
    logic inc_row;
    logic acc_rd;
    logic acc_wr;
    logic scan_rd;
    logic scan_step;
    logic pair_end;
    logic fresh;
  } ctrl_t;

  typedef struct packed {
    logic load_last;
    logic row_last;
    logic r_last;
    logic l_last;
  } stat_t;
endpackage
`default_nettype wire

// File: rtl/core/mss_datapath.sv
// Datapath: matrix store, row sum memory, Kadane scan and best tracking.
`default_nettype none
`include "assert_macros.svh"
module mss_datapath (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire mss_pkg::ctrl_t ctrl,
  output mss_pkg::stat_t stat,
  input  wire logic [mss_pkg::RowW:0] rows,
  input  wire logic [mss_pkg::ColW:0] cols,
  input  wire logic signed [mss_pkg::DataWidth-1:0] value,
  output logic [mss_pkg::IdxW-1:0] top_row,
  output logic [mss_pkg::IdxW-1:0] left_col,
  output logic [mss_pkg::IdxW-1:0] bottom_row,
  output logic [mss_pkg::IdxW-1:0] right_col,
  output logic signed [mss_pkg::OutSumW-1:0] max_sum
);
  import mss_pkg::*;
  logic signed [DataWidth-1:0] mat_mem [MaxRows*MaxCols];
  logic signed [AccW-1:0] rs_mem [MaxRows];
  logic [AddrW:0] load_r;
  logic [AddrW-1:0] base_r;
  logic [ColW-1:0] l_r, r_r;
  logic [RowW-1:0] row_r, row_d_r;
  logic signed [DataWidth-1:0] mat_q_r;
  logic signed [AccW-1:0] rs_q_r;
  logic signed [SumW-1:0] run_r, rbest_r, best_r;
  logic [RowW-1:0] start_r, top_r, bot_r, btop_r, bbot_r;
  logic [ColW-1:0] bl_r, br_r;
  logic run_ok_r;
  logic [AddrW:0] total;
  logic signed [SumW-1:0] run_nxt;
  logic [RowW-1:0] start_nxt;
  logic signed [AccW-1:0] acc_nxt;

  assign total = (AddrW+1)'(rows) * (AddrW+1)'(cols);
  assign stat.load_last = (load_r + 1'b1) == total;
  assign stat.row_last = ({1'b0, row_r} + 1'b1) == (RowW+1)'(rows);
  assign stat.r_last = ({1'b0, r_r} + 1'b1) == (ColW+1)'(cols);
  assign stat.l_last = ({1'b0, l_r} + 1'b1) == (ColW+1)'(cols);
  assign acc_nxt = ctrl.fresh ? AccW'(mat_q_r) : rs_q_r + AccW'(mat_q_r);

  always_comb begin
    if (!run_ok_r || run_r > 0) begin
      run_nxt = run_ok_r ? run_r + SumW'(rs_q_r) : SumW'(rs_q_r);
      start_nxt = run_ok_r ? start_r : row_d_r;
    end else begin
      run_nxt = SumW'(rs_q_r);
      start_nxt = row_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_we) mat_mem[load_r[AddrW-1:0]] <= value;
    if (ctrl.acc_rd) mat_q_r <= mat_mem[base_r + AddrW'(r_r)];
    if (ctrl.acc_rd || ctrl.scan_rd) rs_q_r <= rs_mem[row_r];
    if (ctrl.acc_wr) rs_mem[row_d_r] <= acc_nxt;
    if (ctrl.acc_rd || ctrl.scan_rd) row_d_r <= row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= '0; l_r <= '0; r_r <= '0; row_r <= '0; base_r <= '0;
      run_r <= '0; run_ok_r <= 1'b0; start_r <= '0; rbest_r <= '0;
      top_r <= '0; bot_r <= '0; best_r <= {1'b1, {(SumW-1){1'b0}}};
      btop_r <= '0; bbot_r <= '0; bl_r <= '0; br_r <= '0;
    end else begin
      if (ctrl.clr_load) load_r <= '0;
      else if (ctrl.load_we) load_r <= load_r + 1'b1;
      if (ctrl.clr_best) best_r <= {1'b1, {(SumW-1){1'b0}}};
      if (ctrl.clr_best) begin
        btop_r <= '0; bbot_r <= '0; bl_r <= '0; br_r <= '0;
      end
      if (ctrl.clr_l) l_r <= '0;
      else if (ctrl.inc_l) l_r <= l_r + 1'b1;
      if (ctrl.set_r_to_l) r_r <= ctrl.clr_l ? '0 : l_r;
      else if (ctrl.inc_r) r_r <= r_r + 1'b1;
      if (ctrl.clr_row) begin
        row_r <= '0; base_r <= '0; run_ok_r <= 1'b0;
      end else if (ctrl.inc_row) begin
        row_r <= row_r + 1'b1;
        base_r <= base_r + AddrW'(cols);
      end
      if (ctrl.scan_step) begin
        run_r <= run_nxt;
        start_r <= start_nxt;
        run_ok_r <= 1'b1;
        if (!run_ok_r) begin
          rbest_r <= run_nxt; top_r <= '0; bot_r <= '0;
        end else if (run_nxt > rbest_r) begin
          rbest_r <= run_nxt; top_r <= start_nxt; bot_r <= row_d_r;
        end
      end
      if (ctrl.pair_end && rbest_r > best_r) begin
        best_r <= rbest_r; btop_r <= top_r; bbot_r <= bot_r; bl_r <= l_r; br_r <= r_r;
      end
    end
  end

  assign top_row = IdxW'(btop_r);
  assign bottom_row = IdxW'(bbot_r);
  assign left_col = IdxW'(bl_r);
  assign right_col = IdxW'(br_r);
  assign max_sum = best_r[OutSumW-1:0];

  `ASSERT_NEXT(a_load_clr, clk, rst_n, ctrl.clr_load, load_r == '0)
  `ASSERT_IMPLIES(a_r_ge_l, clk, rst_n, ctrl.scan_step, r_r >= l_r)
  `ASSERT_IMPLIES(a_no_mix, clk, rst_n, ctrl.acc_wr, !ctrl.scan_step)
endmodule
`default_nettype wire

// File: rtl/core/mss_ctrl.sv
// Controller state machine sequencing load, accumulate and scan passes.
`default_nettype none
`include "assert_macros.svh"
module mss_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic cfg_wr,
  input  wire mss_pkg::stat_t stat,
  output mss_pkg::ctrl_t ctrl,
  output logic busy,
  output logic done
);
  import mss_pkg::*;
  state_t state_r, state_nxt;
  logic fresh_r, fresh_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; fresh_r <= 1'b1;
    end else begin
      state_r <= state_nxt; fresh_r <= fresh_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    fresh_nxt = fresh_r;
    ctrl = '0;
    ctrl.fresh = fresh_r;
    busy = 1'b1;
    done = 1'b0;
    case (state_r)
      ST_LOAD: begin
        busy = 1'b0;
        if (cfg_wr) ctrl.clr_load = 1'b1;
        else if (start) begin
          ctrl.load_we = 1'b1;
          if (stat.load_last) begin
            ctrl.clr_load = 1'b1; ctrl.clr_best = 1'b1; ctrl.clr_l = 1'b1;
            ctrl.set_r_to_l = 1'b1; ctrl.clr_row = 1'b1;
            fresh_nxt = 1'b1;
            state_nxt = ST_ACCUM;
          end
        end
      end
      ST_COL_INIT: begin
        ctrl.set_r_to_l = 1'b1; ctrl.clr_row = 1'b1;
        fresh_nxt = 1'b1;
        state_nxt = ST_ACCUM;
      end
      ST_ACCUM: begin
        ctrl.acc_rd = 1'b1;
        state_nxt = ST_ACCUM_WAIT;
      end
      ST_ACCUM_WAIT: begin
        ctrl.acc_wr = 1'b1;
        if (stat.row_last) begin
          ctrl.clr_row = 1'b1; state_nxt = ST_SCAN;
        end else begin
          ctrl.inc_row = 1'b1; state_nxt = ST_ACCUM;
        end
      end
      ST_SCAN: begin
        ctrl.scan_rd = 1'b1;
        state_nxt = ST_SCAN_WAIT;
      end
      ST_SCAN_WAIT: begin
        ctrl.scan_step = 1'b1;
        if (stat.row_last) state_nxt = ST_PAIR_END;
        else begin
          ctrl.inc_row = 1'b1; state_nxt = ST_SCAN;
        end
      end
      ST_PAIR_END: begin
        ctrl.pair_end = 1'b1;
        fresh_nxt = 1'b0;
        if (!stat.r_last) begin
          ctrl.inc_r = 1'b1; ctrl.clr_row = 1'b1; state_nxt = ST_ACCUM;
        end else if (!stat.l_last) begin
          ctrl.inc_l = 1'b1; state_nxt = ST_COL_INIT;
        end else state_nxt = ST_DONE;
      end
      ST_DONE: begin
        done = 1'b1;
        state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  `ASSERT_IMPLIES(a_done_busy, clk, rst_n, done, busy)
  `ASSERT_NEXT(a_done_load, clk, rst_n, done, state_r == ST_LOAD)
  `ASSERT_IMPLIES(a_we_idle, clk, rst_n, ctrl.load_we, !busy)
endmodule
`default_nettype wire

// File: rtl/core/max_sum_subrectangle_top.sv
// Top level of the maximum-sum subrectangle search block.
// Elements are taken one request per cycle while busy is low. After the last element the
// search visits every column pair in two passes (accumulate and scan) over the single-port
// row sum and matrix memories, with a column init step before each left column after the
// first, and the one result then appears for exactly one cycle on out_valid; the receiver
// cannot stall it. A configuration write is taken only while busy and start are low, and it
// restarts loading of the matrix.
`default_nettype none
module max_sum_subrectangle_top (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic signed [mss_pkg::DataWidth-1:0] in_value,
  output logic out_valid,
  output logic [mss_pkg::IdxW-1:0] out_top_row,
  output logic [mss_pkg::IdxW-1:0] out_left_col,
  output logic [mss_pkg::IdxW-1:0] out_bottom_row,
  output logic [mss_pkg::IdxW-1:0] out_right_col,
  output logic signed [mss_pkg::OutSumW-1:0] out_max_sum,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [mss_pkg::DimW-1:0] cfg_data
);
  import mss_pkg::*;
  ctrl_t ctrl;
  stat_t stat;
  logic [RowW:0] rows_r;
  logic [ColW:0] cols_r;
  logic cfg_wr;

  assign cfg_ready = !busy && !start;
  assign cfg_wr = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= (RowW+1)'(MaxRows); cols_r <= (ColW+1)'(MaxCols);
    end else if (cfg_wr) begin
      if (cfg_index == CfgRowCount) begin
        rows_r <= (cfg_data == '0) ? (RowW+1)'(1) :
                  (cfg_data > DimW'(MaxRows)) ? (RowW+1)'(MaxRows) : (RowW+1)'(cfg_data);
      end else begin
        cols_r <= (cfg_data == '0) ? (ColW+1)'(1) :
                  (cfg_data > DimW'(MaxCols)) ? (ColW+1)'(MaxCols) : (ColW+1)'(cfg_data);
      end
    end
  end

  mss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .cfg_wr(cfg_wr), .stat(stat),
    .ctrl(ctrl), .busy(busy), .done(out_valid)
  );

  mss_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat), .rows(rows_r), .cols(cols_r),
    .value(in_value), .top_row(out_top_row), .left_col(out_left_col),
    .bottom_row(out_bottom_row), .right_col(out_right_col), .max_sum(out_max_sum)
  );
endmodule
`default_nettype wire
